// ===== rtl/shp_pkg.sv =====
`default_nettype none

package shp_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  // Kernel sum grows by five bits: the worst case is seventeen times a full-scale pixel
  localparam int SUM_GROW = 5;

  localparam int MODE_BITS      = 2;
  localparam int WIDTH_BITS     = 13;
  localparam int HEIGHT_BITS    = 16;
  localparam int ROW_BITS       = HEIGHT_BITS + 1;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MODE_BITS-1:0] KM_CROSS    = 2'd0;
  localparam logic [MODE_BITS-1:0] KM_FULL     = 2'd1;
  localparam logic [MODE_BITS-1:0] KM_WEIGHTED = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [MODE_BITS-1:0]   MODE_RST   = KM_CROSS;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 16'd480;

  // Per-item control handed from the position counters to the line store stage
  typedef struct packed {
    logic br1;   // row start: result taken from the window before the shift
    logic emit;  // item produces a result
    logic x0;    // result column is the first one
    logic xl;    // result column is the last one
    logic y0;    // result row is the first one
    logic yl;    // result row is the last one
    logic eof;   // result is the last of the frame
  } tap_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/shp_ctrl.sv =====
`default_nettype none

module shp_ctrl #(
  parameter int MAX_WIDTH  = shp_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = shp_pkg::PIXEL_BITS_DEF,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 restart,
  input  wire logic [AW-1:0]                        w_last,
  input  wire logic [shp_pkg::HEIGHT_BITS-1:0]      h_last,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_cmd,
  input  wire logic [PIXEL_BITS-1:0]                in_pixel_in,
  input  wire logic                                 acc_ready,
  output logic                                      acc_valid,
  output logic [AW-1:0]                             acc_addr,
  output logic [PIXEL_BITS-1:0]                     acc_pixel,
  output shp_pkg::tap_ctrl_t                        acc_ctrl
);

  localparam int RW = shp_pkg::ROW_BITS;

  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] h_plus1, h_plus2;
  logic          tail, take, col_zero, br1, br2;

  assign h_plus1  = RW'(h_last) + RW'(1);
  assign h_plus2  = RW'(h_last) + RW'(2);
  assign tail     = row_r > RW'(h_last);
  assign take     = tail ? (in_cmd == shp_pkg::CMD_DRAIN) : (in_cmd == shp_pkg::CMD_PIXEL);
  assign col_zero = col_r == '0;
  assign br1      = col_zero && (row_r >= RW'(2));
  assign br2      = !col_zero && (row_r != '0);

  assign in_ready  = acc_ready;
  // ignored items transfer but leave no trace
  assign acc_valid = in_valid && in_ready && take;
  assign acc_addr  = col_r;
  assign acc_pixel = tail ? '0 : in_pixel_in;

  always_comb begin
    acc_ctrl.br1  = br1;
    acc_ctrl.emit = br1 || br2;
    acc_ctrl.x0   = br1 ? (w_last == '0) : (col_r == AW'(1));
    acc_ctrl.xl   = br1;
    acc_ctrl.y0   = br1 ? (row_r == RW'(2)) : (row_r == RW'(1));
    acc_ctrl.yl   = br1 ? (row_r == h_plus2) : (row_r == h_plus1);
    acc_ctrl.eof  = br1 && (row_r == h_plus2);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc_valid) begin
      if (acc_ctrl.eof) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == w_last) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n) col_r <= w_last)
    else $error("column counter beyond the last column");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n) row_r <= h_plus2)
    else $error("row counter beyond the frame tail");

endmodule

`default_nettype wire

// ===== rtl/shp_line_mem.sv =====
`default_nettype none

module shp_line_mem #(
  parameter int MAX_WIDTH  = shp_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = shp_pkg::PIXEL_BITS_DEF,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             restart,
  input  wire logic                             acc_valid,
  output logic                                  acc_ready,
  input  wire logic [AW-1:0]                    acc_addr,
  input  wire logic [PIXEL_BITS-1:0]            acc_pixel,
  input  wire shp_pkg::tap_ctrl_t               acc_ctrl,
  output logic                                  tap_valid,
  input  wire logic                             tap_ready,
  output logic [8:0][PIXEL_BITS-1:0]            taps,
  output logic                                  tap_eor,
  output logic                                  tap_eof
);

  localparam int PB = PIXEL_BITS;

  // Each entry holds {row two back, row one back} for one column
  logic [2*PB-1:0] line_r [MAX_WIDTH];
  logic [2*PB-1:0] rd_q_r, fwd_data_r, rd_word, wr_word;
  logic            fwd_r, s1_valid_r, s1_adv, s2_free;
  logic [AW-1:0]   s1_addr_r;
  logic [PB-1:0]   s1_pix_r;
  shp_pkg::tap_ctrl_t s1_ctrl_r;

  logic [2:0][2:0][PB-1:0] win_r, win_shift, win_src;
  logic [1:0]              col_sel [3];
  logic [1:0]              row_sel [3];
  logic [8:0][PB-1:0]      taps_r, taps_nxt;
  logic                    tap_valid_r, tap_eor_r, tap_eof_r;

  assign rd_word = fwd_r ? fwd_data_r : rd_q_r;
  assign wr_word = {rd_word[PB-1:0], s1_pix_r};

  assign s2_free   = !tap_valid_r || tap_ready;
  assign s1_adv    = s1_valid_r && (!s1_ctrl_r.emit || s2_free);
  assign acc_ready = !s1_valid_r || s1_adv;

  always_comb begin
    win_shift[0]    = win_r[1];
    win_shift[1]    = win_r[2];
    win_shift[2][0] = rd_word[2*PB-1:PB];
    win_shift[2][1] = rd_word[PB-1:0];
    win_shift[2][2] = s1_pix_r;
    win_src         = s1_ctrl_r.br1 ? win_r : win_shift;
  end

  // Replicate the nearest edge pixel for neighbours outside the image
  always_comb begin
    col_sel[0] = s1_ctrl_r.x0 ? 2'd1 : 2'd0;
    col_sel[1] = 2'd1;
    col_sel[2] = s1_ctrl_r.xl ? 2'd1 : 2'd2;
    row_sel[0] = s1_ctrl_r.y0 ? 2'd1 : 2'd0;
    row_sel[1] = 2'd1;
    row_sel[2] = s1_ctrl_r.yl ? 2'd1 : 2'd2;
    for (int col = 0; col < 3; col++) begin
      for (int row = 0; row < 3; row++) begin
        taps_nxt[col*3+row] = win_src[col_sel[col]][row_sel[row]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_valid) begin
      rd_q_r <= line_r[acc_addr];
    end
    if (s1_adv) begin
      line_r[s1_addr_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_valid) begin
      s1_addr_r  <= acc_addr;
      s1_pix_r   <= acc_pixel;
      s1_ctrl_r  <= acc_ctrl;
      fwd_data_r <= wr_word;
    end
    if (s1_adv && s1_ctrl_r.emit) begin
      taps_r    <= taps_nxt;
      tap_eor_r <= s1_ctrl_r.xl;
      tap_eof_r <= s1_ctrl_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      tap_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      if (acc_valid) begin
        s1_valid_r <= 1'b1;
        // the read misses a write to the same column in this cycle: take it from here
        fwd_r      <= s1_adv && (s1_addr_r == acc_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_ctrl_r.emit) begin
        tap_valid_r <= 1'b1;
      end else if (tap_ready) begin
        tap_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= s1_ctrl_r.eof ? '0 : win_shift;
    end
  end

  assign tap_valid = tap_valid_r;
  assign taps      = taps_r;
  assign tap_eor   = tap_eor_r;
  assign tap_eof   = tap_eof_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    acc_valid |-> (!s1_valid_r || s1_adv))
    else $error("item taken while the line store stage is held");
  a_fwd_set: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_valid && s1_adv && (acc_addr == s1_addr_r)) |=> fwd_r)
    else $error("same-column write not forwarded");

endmodule

`default_nettype wire

// ===== rtl/shp_kernel.sv =====
`default_nettype none

module shp_kernel #(
  parameter int PIXEL_BITS = shp_pkg::PIXEL_BITS_DEF,
  localparam int SW        = PIXEL_BITS + shp_pkg::SUM_GROW
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [shp_pkg::MODE_BITS-1:0]     kernel_mode,
  input  wire logic                              tap_valid,
  output logic                                   tap_ready,
  input  wire logic [8:0][PIXEL_BITS-1:0]        taps,
  input  wire logic                              tap_eor,
  input  wire logic                              tap_eof,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [SW-1:0]                   out_pixel_out,
  output logic                                   out_end_of_row,
  output logic                                   out_end_of_frame
);

  logic signed [SW-1:0] t [9];
  logic signed [SW-1:0] centre5, centre9, edges, corners, sum;
  logic signed [SW-1:0] pix_r;
  logic                 out_valid_r, eor_r, eof_r;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      t[i] = SW'($signed(taps[i]));
    end
  end

  assign centre5 = (t[4] <<< 2) + t[4];
  assign centre9 = (t[4] <<< 3) + t[4];
  assign edges   = t[1] + t[3] + t[5] + t[7];
  assign corners = t[0] + t[2] + t[6] + t[8];

  always_comb begin
    case (kernel_mode)
      shp_pkg::KM_CROSS:    sum = centre5 - edges;
      shp_pkg::KM_FULL:     sum = centre9 - edges - corners;
      shp_pkg::KM_WEIGHTED: sum = centre5 + corners - (edges <<< 1);
      default:              sum = '0;
    endcase
  end

  assign tap_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tap_ready) begin
      out_valid_r <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tap_valid && tap_ready) begin
      pix_r <= sum;
      eor_r <= tap_eor;
      eof_r <= tap_eof;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = pix_r;
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;

  a_eof_is_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && eof_r) |-> eor_r)
    else $error("frame end flagged away from a row end");

endmodule

`default_nettype wire

// ===== rtl/sharpen_3x3_convolution_top.sv =====
// Item completing a neighbourhood -> line store stage -> tap register -> out_valid register;
//   results trail the pixel stream by image_width+1 items, drain items flush the frame tail.
// Throughput: one item per cycle unless out_ready stalls, set by the line store's 1R1W ports.
// Reset: synchronous, active low; config returns to cross kernel, 640 x 480, position counters
//   and window clear. The line store is not cleared: columns not yet written are replaced by
//   the edge rule before they can reach a result.
`default_nettype none

module sharpen_3x3_convolution_top #(
  parameter int MAX_WIDTH  = shp_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = shp_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       cfg_we,
  input  wire logic [shp_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
  input  wire logic [shp_pkg::CFG_DATA_BITS-1:0]          cfg_data,
  input  wire logic                                       in_valid,
  output logic                                            in_ready,
  input  wire logic                                       in_cmd,
  input  wire logic signed [PIXEL_BITS-1:0]               in_pixel_in,
  output logic                                            out_valid,
  input  wire logic                                       out_ready,
  output logic signed [PIXEL_BITS+shp_pkg::SUM_GROW-1:0]  out_pixel_out,
  output logic                                            out_end_of_row,
  output logic                                            out_end_of_frame
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WB = shp_pkg::WIDTH_BITS;
  localparam int HB = shp_pkg::HEIGHT_BITS;
  localparam logic [AW-1:0] W_LAST_MAX = AW'(MAX_WIDTH - 1);

  logic [shp_pkg::MODE_BITS-1:0] kernel_mode_r;
  logic [WB-1:0]                 image_width_r;
  logic [HB-1:0]                 image_height_r;
  logic                          restart;
  logic [AW-1:0]                 w_last;
  logic [HB-1:0]                 h_last;

  logic                          acc_valid, acc_ready;
  logic [AW-1:0]                 acc_addr;
  logic [PIXEL_BITS-1:0]         acc_pixel;
  shp_pkg::tap_ctrl_t            acc_ctrl;
  logic                          tap_valid, tap_ready, tap_eor, tap_eof;
  logic [8:0][PIXEL_BITS-1:0]    taps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r  <= shp_pkg::MODE_RST;
      image_width_r  <= shp_pkg::WIDTH_RST;
      image_height_r <= shp_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shp_pkg::CFG_KERNEL_MODE:  kernel_mode_r  <= cfg_data[shp_pkg::MODE_BITS-1:0];
        shp_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WB-1:0];
        shp_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[HB-1:0];
        default: ;
      endcase
    end
  end

  // any register write restarts the frame
  always_comb begin
    unique case (cfg_index)
      shp_pkg::CFG_KERNEL_MODE,
      shp_pkg::CFG_IMAGE_WIDTH,
      shp_pkg::CFG_IMAGE_HEIGHT: restart = cfg_we;
      default:                   restart = 1'b0;
    endcase
  end

  // zero counts as one, widths above the line store clamp to its depth
  always_comb begin
    if (image_width_r == '0) begin
      w_last = '0;
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_last = W_LAST_MAX;
    end else begin
      w_last = AW'(image_width_r - WB'(1));
    end
    h_last = (image_height_r == '0) ? '0 : image_height_r - HB'(1);
  end

  shp_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .w_last      (w_last),
    .h_last      (h_last),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_pixel_in (in_pixel_in),
    .acc_ready   (acc_ready),
    .acc_valid   (acc_valid),
    .acc_addr    (acc_addr),
    .acc_pixel   (acc_pixel),
    .acc_ctrl    (acc_ctrl)
  );

  shp_line_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc_addr  (acc_addr),
    .acc_pixel (acc_pixel),
    .acc_ctrl  (acc_ctrl),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .taps      (taps),
    .tap_eor   (tap_eor),
    .tap_eof   (tap_eof)
  );

  shp_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .clk              (clk),
    .rst_n            (rst_n),
    .kernel_mode      (kernel_mode_r),
    .tap_valid        (tap_valid),
    .tap_ready        (tap_ready),
    .taps             (taps),
    .tap_eor          (tap_eor),
    .tap_eof          (tap_eof),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int MAX_W        = shp_pkg::MAX_WIDTH_DEF;
  localparam int PIX_W        = shp_pkg::PIXEL_BITS_DEF;
  localparam int SUM_W        = shp_pkg::PIXEL_BITS_DEF + shp_pkg::SUM_GROW;
  localparam int MODE_W       = shp_pkg::MODE_BITS;
  localparam int WID_W        = shp_pkg::WIDTH_BITS;
  localparam int HGT_W        = shp_pkg::HEIGHT_BITS;
  localparam int IDX_W        = shp_pkg::CFG_INDEX_BITS;
  localparam int CFG_W        = shp_pkg::CFG_DATA_BITS;
  localparam int MODE_HI_W    = CFG_W - MODE_W;
  localparam int WID_HI_W     = CFG_W - WID_W;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 16;
  localparam int CYCLE_LIMIT  = 2000000;

  localparam logic [MODE_W-1:0] KM_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_LIST [4] =
    '{shp_pkg::KM_CROSS, shp_pkg::KM_FULL, shp_pkg::KM_WEIGHTED, KM_UNUSED};

  typedef struct packed {
    logic signed [SUM_W-1:0] pixel_out;
    logic                    end_of_row;
    logic                    end_of_frame;
  } sharp_pix_t;

  class sharpen_scoreboard;
    logic [MODE_W-1:0]       mode;
    logic [WID_W-1:0]        width_reg;
    logic [HGT_W-1:0]        height_reg;
    logic signed [PIX_W-1:0] line_mem [2*MAX_W];
    logic signed [PIX_W-1:0] win [9];   // col*3+row, col 0 left, row 0 top
    int unsigned             col;
    int unsigned             row;
    sharp_pix_t              expected_pixels [$];
    int                      errors;

    function new();
      mode       = shp_pkg::MODE_RST;
      width_reg  = shp_pkg::WIDTH_RST;
      height_reg = shp_pkg::HEIGHT_RST;
      foreach (line_mem[i]) line_mem[i] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      col = 0;
      row = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (32'(width_reg) > MAX_W) return MAX_W;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        shp_pkg::CFG_KERNEL_MODE:  mode = val[MODE_W-1:0];
        shp_pkg::CFG_IMAGE_WIDTH:  width_reg = val[WID_W-1:0];
        shp_pkg::CFG_IMAGE_HEIGHT: height_reg = val[HGT_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    // Returns 1 when the transfer is consumed, 0 when the block ignores it
    function bit take_item(logic cmd, logic signed [PIX_W-1:0] pix);
      int unsigned             w, h, c, r, x, y, i;
      logic signed [PIX_W-1:0] v, top, mid;
      logic signed [PIX_W-1:0] t [9];
      bit                      emit;
      int                      s;
      sharp_pix_t              res;
      w = eff_width();
      h = eff_height();
      c = (col >= w) ? w - 1 : col;
      r = row;
      emit = 1'b0;
      x = 0;
      y = 0;
      if (r >= h) begin
        if (cmd != shp_pkg::CMD_DRAIN) return 1'b0;
        v = '0;
      end else begin
        if (cmd != shp_pkg::CMD_PIXEL) return 1'b0;
        v = pix;
      end
      // row start: the window still holds the last column of the row two up
      if (c == 0 && r >= 2) begin
        t = win;
        x = w - 1;
        y = r - 2;
        emit = 1'b1;
      end
      top = line_mem[c];
      mid = line_mem[MAX_W + c];
      line_mem[c] = mid;
      line_mem[MAX_W + c] = v;
      for (i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6] = top;
      win[7] = mid;
      win[8] = v;
      if (c >= 1 && r >= 1) begin
        t = win;
        x = c - 1;
        y = r - 1;
        emit = 1'b1;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
      if (!emit) return 1'b1;

      // replicate the nearest edge pixel
      if (x == 0)     for (i = 0; i < 3; i++) t[i] = t[3 + i];
      if (x == w - 1) for (i = 0; i < 3; i++) t[6 + i] = t[3 + i];
      if (y == 0)     for (i = 0; i < 3; i++) t[i*3] = t[i*3 + 1];
      if (y == h - 1) for (i = 0; i < 3; i++) t[i*3 + 2] = t[i*3 + 1];

      case (mode)
        shp_pkg::KM_CROSS:    s = 5*t[4] - t[1] - t[7] - t[3] - t[5];
        shp_pkg::KM_FULL:     s = 9*t[4] - t[0] - t[1] - t[2] - t[3] - t[5] - t[6] - t[7]
                                  - t[8];
        shp_pkg::KM_WEIGHTED: s = 5*t[4] + t[0] + t[2] + t[6] + t[8]
                                  - 2*(t[1] + t[3] + t[5] + t[7]);
        default:              s = 0;
      endcase

      res.pixel_out    = s[SUM_W-1:0];
      res.end_of_row   = (x == w - 1);
      res.end_of_frame = (x == w - 1) && (y == h - 1);
      expected_pixels.push_back(res);
      if (res.end_of_frame) restart();
      return 1'b1;
    endfunction

    function void check_pixel(logic signed [SUM_W-1:0] px, logic eor, logic eof);
      sharp_pix_t exp_pix;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %0d end_of_row %0b end_of_frame %0b", px, eor, eof);
        errors++;
        return;
      end
      exp_pix = expected_pixels.pop_front();
      if (px !== exp_pix.pixel_out) begin
        $error("pixel_out: expected %0d, actual %0d", exp_pix.pixel_out, px);
        errors++;
      end
      if (eor !== exp_pix.end_of_row) begin
        $error("end_of_row: expected %0b, actual %0b", exp_pix.end_of_row, eor);
        errors++;
      end
      if (eof !== exp_pix.end_of_frame) begin
        $error("end_of_frame: expected %0b, actual %0b", exp_pix.end_of_frame, eof);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [IDX_W-1:0]              cfg_index = shp_pkg::CFG_KERNEL_MODE;
  logic [CFG_W-1:0]              cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_cmd = shp_pkg::CMD_PIXEL;
  logic signed [PIX_W-1:0]       in_pixel_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SUM_W-1:0]       out_pixel_out;
  logic                          out_end_of_row;
  logic                          out_end_of_frame;

  sharpen_scoreboard sb;
  int  burst_left = 0;
  int  items_done = 0;
  int  cycle_count = 0;
  bit  hold_off_req = 1'b0;

  sharpen_3x3_convolution_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_out    (out_pixel_out),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Everything settles by the falling edge; a transfer happens at the next rising edge
  initial begin : result_monitor
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_pixel(out_pixel_out, out_end_of_row, out_end_of_frame);
    end
  end

  initial begin : result_sink
    int pat;
    int span;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pat  = $urandom_range(0, 4);
      span = $urandom_range(1, 24);
      if (pat == 0) span = span * 4;
      repeat (span) begin
        // start a requested hold at once
        if (hold_off_req) break;
        case (pat)
          0, 1:    out_ready <= 1'b1;
          2:       out_ready <= 1'b0;
          3:       out_ready <= ~out_ready;
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic signed [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(PIX_W-1){1'b0}}};
      1:       return {1'b0, {(PIX_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic offer_item(input logic cmd, input logic signed [PIX_W-1:0] pix);
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_pixel_in <= pix;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (sb.take_item(cmd, pix)) items_done++;
  endtask

  // Drop valid, collect every outstanding result, then let the pipeline empty
  task automatic settle_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_block(input logic [CFG_W-1:0] mode_v,
                               input logic [CFG_W-1:0] width_v,
                               input logic [CFG_W-1:0] height_v);
    settle_block();
    write_reg(shp_pkg::CFG_KERNEL_MODE, mode_v);
    write_reg(shp_pkg::CFG_IMAGE_WIDTH, width_v);
    write_reg(shp_pkg::CFG_IMAGE_HEIGHT, height_v);
    cfg_we <= 1'b0;
  endtask

  // A frame with stray drains mid-frame and stray pixels in the tail; cut_at > 0 stops early
  task automatic run_frame(input int unsigned cut_at);
    int unsigned w, h, n;
    w = sb.eff_width();
    h = sb.eff_height();
    for (n = 0; n < w * h; n++) begin
      if (cut_at != 0 && n == cut_at) return;
      if ($urandom_range(0, 99) < 4) offer_item(shp_pkg::CMD_DRAIN, PIX_W'($urandom));
      offer_item(shp_pkg::CMD_PIXEL, pick_pixel());
    end
    for (n = 0; n <= w; n++) begin
      if ($urandom_range(0, 99) < 4) offer_item(shp_pkg::CMD_PIXEL, pick_pixel());
      offer_item(shp_pkg::CMD_DRAIN, PIX_W'($urandom));
    end
    if ($urandom_range(0, 9) == 0) offer_item(shp_pkg::CMD_DRAIN, PIX_W'($urandom));
  endtask

  initial begin : stimulus
    logic signed [PIX_W-1:0] peak [9];
    logic [CFG_W-1:0]        mode_v, width_v, height_v;
    int unsigned             n_frames, f, phase;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 640 wide, so the first results need a row and a bit
    run_frame(660);

    // largest positive and negative sums on a 3x3 frame
    program_block(CFG_W'(shp_pkg::KM_FULL), CFG_W'(3), CFG_W'(3));
    peak = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
             16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    offer_item(shp_pkg::CMD_DRAIN, 16'sh7fff);
    foreach (peak[i]) offer_item(shp_pkg::CMD_PIXEL, peak[i]);
    offer_item(shp_pkg::CMD_DRAIN, '0);
    offer_item(shp_pkg::CMD_DRAIN, '1);
    offer_item(shp_pkg::CMD_PIXEL, 16'sh1234);
    offer_item(shp_pkg::CMD_DRAIN, '0);
    offer_item(shp_pkg::CMD_DRAIN, '0);
    offer_item(shp_pkg::CMD_DRAIN, '0);
    foreach (peak[i]) offer_item(shp_pkg::CMD_PIXEL, ~peak[i]);
    repeat (4) offer_item(shp_pkg::CMD_DRAIN, '0);

    // zero size means one pixel
    program_block(CFG_W'(shp_pkg::KM_WEIGHTED), '0, '0);
    run_frame(0);
    program_block(CFG_W'(KM_UNUSED), CFG_W'(1), CFG_W'(1));
    run_frame(0);

    // single-column frame of the tallest height, cut short
    program_block(CFG_W'(shp_pkg::KM_FULL), CFG_W'(1), 16'hffff);
    run_frame(30);

    items_done = 0;
    phase = 0;
    while (items_done < RANDOM_ITEMS) begin
      mode_v = CFG_W'(MODE_LIST[$urandom_range(0, 3)]);
      if ($urandom_range(0, 7) == 0) mode_v[CFG_W-1:MODE_W] = MODE_HI_W'($urandom);
      case ($urandom_range(0, 9))
        0:       width_v = '0;
        1, 2:    width_v = CFG_W'($urandom_range(9, 40));
        default: width_v = CFG_W'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 7) == 0) width_v[CFG_W-1:WID_W] = WID_HI_W'($urandom);
      case ($urandom_range(0, 9))
        0:       height_v = '0;
        1:       height_v = CFG_W'($urandom_range(7, 12));
        default: height_v = CFG_W'($urandom_range(1, 6));
      endcase
      n_frames = $urandom_range(1, 3);
      if (phase == 0) begin
        width_v  = CFG_W'(8);
        height_v = CFG_W'(6);
        n_frames = 2;
      end
      program_block(mode_v, width_v, height_v);
      // stall the result side for a long stretch while transfers keep coming
      if (phase == 0) hold_off_req = 1'b1;
      for (f = 0; f < n_frames; f++) begin
        if ($urandom_range(0, 9) == 0) begin
          run_frame($urandom_range(1, sb.eff_width() * sb.eff_height()));
          break;
        end
        run_frame(0);
      end
      phase++;
    end

    settle_block();
    if (sb.errors == 0 && sb.expected_pixels.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/shp_pkg.sv
rtl/shp_ctrl.sv
rtl/shp_line_mem.sv
rtl/shp_kernel.sv
rtl/sharpen_3x3_convolution_top.sv
verif/tb.sv
